// File: rtl/running_mean_variance_assert.svh
// assertion macros used by the running mean and variance port checker
`ifndef RUNNING_MEAN_VARIANCE_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_ASSERT_SVH

// same-cycle implication
`define RMV_ASSERT_IMP(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("running_mean_variance: same-cycle check failed");

// next-cycle implication
`define RMV_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("running_mean_variance: next-cycle check failed");

`endif

// File: rtl/rmv_pkg.sv
// shared constants and types of the running mean and variance block
`default_nettype none

package rmv_pkg;

  localparam int COUNT_BITS  = 32;
  localparam int SAMPLE_BITS = 32;

  // fixed field widths of the channels
  localparam int SAMPLE_FIELD_BITS = 32;
  localparam int TOTAL_BITS        = 32;
  localparam int MEAN_BITS         = 32;
  localparam int VAR_BITS          = 64;

  // magnitude of a difference of two samples
  localparam int MAG_BITS  = SAMPLE_BITS + 1;
  localparam int HALF_BITS = (MAG_BITS + 1) / 2;
  localparam int PP_BITS   = 2 * HALF_BITS;
  localparam int ACC_BITS  = 4 * HALF_BITS;

  // shared divider
  localparam int DIV_BITS      = VAR_BITS;
  localparam int DIV_STEP_BITS = $clog2(DIV_BITS + 1);

  // queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // count widened so the total field can saturate
  localparam int WIDE_BITS = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;
  localparam logic [63:0] TOTAL_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start;
  } rmv_item_t;

  typedef struct packed {
    logic                     start;
    logic [DIV_BITS-1:0]      dividend;
    logic [COUNT_BITS-1:0]    divisor;
    logic [DIV_STEP_BITS-1:0] steps;
  } rmv_div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quotient;
  } rmv_div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/rmv_if.sv
// request channels of the running mean and variance block
`default_nettype none

interface rmv_in_if import rmv_pkg::*; ();
  logic                                valid;
  logic                                ready;
  logic signed [SAMPLE_FIELD_BITS-1:0] sample;
  logic                                start_new_set;

  modport source (output valid, sample, start_new_set, input ready);
  modport sink (input valid, sample, start_new_set, output ready);
endinterface

interface rmv_out_if import rmv_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [TOTAL_BITS-1:0]       sample_total;
  logic signed [MEAN_BITS-1:0] mean_value;
  logic [VAR_BITS-1:0]         variance_value;
  logic                        variance_valid;

  modport source (output valid, sample_total, mean_value, variance_value, variance_valid,
                  input ready);
  modport sink (input valid, sample_total, mean_value, variance_value, variance_valid,
                output ready);
endinterface

`default_nettype wire

// File: rtl/running_mean_variance.sv
// Running mean and sample variance of a stream of Q16.16 samples.
// in_chan carries one request per sample: the sample and a start_new_set flag
// that clears count, mean and spread before the sample is added.
// out_chan returns one result per request, in order: the count (saturating
// at 32 bits), the Q16.16 mean and the Q32.32 variance with its valid flag.
// Both channels move a request when valid and ready are high at a clock edge.
// The back end takes one sample at a time; its update time is set by the shared
// divider that yields one quotient bit a cycle: 33 steps for the mean update
// and 64 for the variance, plus a partial-product multiply (load, low-low,
// low-high, high-low, high-high) and sequencing. With fewer than two samples
// held the variance division is skipped. The front queue is registered.
// A two-deep queue takes further requests while the back end is busy, and
// the output register lets the next update start while a result waits.
// A stalled receiver holds the result steady; the back end then waits with
// its next result and the queue fills until in_chan.ready drops.
// Synchronous active-low reset clears count, mean, spread and the output valid.
`default_nettype none

module running_mean_variance import rmv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rmv_in_if.sink    in_chan,
  rmv_out_if.source out_chan
);

  rmv_item_t    item;
  logic         item_valid;
  logic         item_ready;
  rmv_div_req_t div_req;
  rmv_div_rsp_t div_rsp;

  rmv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  rmv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rmv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

// File: rtl/rmv_front.sv
// front end: takes requests, trims the sample and queues them for the back end
`default_nettype none

module rmv_front import rmv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rmv_in_if.sink    in_chan,
  output rmv_item_t item,
  output logic      item_valid,
  input  logic      item_ready
);

  rmv_item_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r;
  logic [QPTR_BITS-1:0]  rd_ptr_r;
  logic [QCNT_BITS-1:0]  fill_r;
  logic                  push;
  logic                  pop;
  rmv_item_t             incoming;

  assign in_chan.ready = (fill_r != QCNT_BITS'(QUEUE_DEPTH));
  assign item_valid    = (fill_r != '0);
  assign item          = q_mem[rd_ptr_r];
  assign push          = in_chan.valid && in_chan.ready;
  assign pop           = item_valid && item_ready;

  // only the low sample bits count, read as two's complement
  always_comb begin
    incoming.sample = in_chan.sample[SAMPLE_BITS-1:0];
    incoming.start  = in_chan.start_new_set;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + QCNT_BITS'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= incoming;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rmv_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module rmv_div import rmv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  rmv_div_req_t req,
  output rmv_div_rsp_t rsp
);

  logic                     busy_r;
  logic                     done_r;
  logic [DIV_STEP_BITS-1:0] cnt_r;
  logic [DIV_BITS-1:0]      quo_r;
  logic [COUNT_BITS-1:0]    rem_r;
  logic [COUNT_BITS-1:0]    dsr_r;
  logic [COUNT_BITS:0]      shifted;
  logic [COUNT_BITS:0]      trial;
  logic                     fits;

  // remainder stays below the divisor, so it fits the divisor width
  assign shifted = {rem_r, quo_r[DIV_BITS-1]};
  assign fits    = (shifted >= {1'b0, dsr_r});
  assign trial   = shifted - {1'b0, dsr_r};

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_STEP_BITS'(1);
        if (cnt_r == DIV_STEP_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_BITS-2:0], fits};
      rem_r <= fits ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/rmv_back.sv
// back end: holds the running state, sequences the update and registers the result
`default_nettype none

module rmv_back import rmv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  rmv_item_t    item,
  input  logic         item_valid,
  output logic         item_ready,
  output rmv_div_req_t div_req,
  input  rmv_div_rsp_t div_rsp,
  rmv_out_if.source    out_chan
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_DMEAN = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_VPREP = 7'b0010000,
    ST_DVAR  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  // steps of the partial-product multiply
  localparam logic [2:0] MS_LOAD = 3'd0;
  localparam logic [2:0] MS_LL   = 3'd1;
  localparam logic [2:0] MS_LH   = 3'd2;
  localparam logic [2:0] MS_HL   = 3'd3;
  localparam logic [2:0] MS_HH   = 3'd4;

  state_t                        state_r, state_nxt;
  logic [COUNT_BITS-1:0]         count_r, count_nxt;
  logic signed [SAMPLE_BITS-1:0] mean_r, mean_nxt;
  logic [VAR_BITS-1:0]           m2_r, m2_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic [MAG_BITS-1:0]           dabs_r, dabs_nxt;
  logic                          dneg_r, dneg_nxt;
  logic [MAG_BITS-1:0]           babs_r, babs_nxt;
  logic [ACC_BITS-1:0]           acc_r, acc_nxt;
  logic [2:0]                    mstep_r, mstep_nxt;
  logic [VAR_BITS-1:0]           var_r, var_nxt;
  logic                          vv_r, vv_nxt;
  logic                          ov_r, ov_nxt;
  logic [TOTAL_BITS-1:0]         otot_r, otot_nxt;
  logic [MEAN_BITS-1:0]          omean_r, omean_nxt;
  logic [VAR_BITS-1:0]           ovar_r, ovar_nxt;
  logic                          ovv_r, ovv_nxt;

  logic [COUNT_BITS-1:0]         base_count;
  logic signed [MAG_BITS-1:0]    delta;
  logic [MAG_BITS-1:0]           dabs;
  logic [MAG_BITS-1:0]           quot;
  logic signed [MAG_BITS:0]      step_val;
  logic signed [MAG_BITS:0]      mean_sum;
  logic [HALF_BITS-1:0]          op_a, op_b;
  logic [PP_BITS-1:0]            pp;
  logic [ACC_BITS-1:0]           add_term;
  logic [VAR_BITS:0]             m2_sum;
  logic [VAR_BITS-1:0]           m2_sat;
  logic [WIDE_BITS-1:0]          wide_count;
  logic [TOTAL_BITS-1:0]         total;

  assign out_chan.valid          = ov_r;
  assign out_chan.sample_total   = otot_r;
  assign out_chan.mean_value     = omean_r;
  assign out_chan.variance_value = ovar_r;
  assign out_chan.variance_valid = ovv_r;

  // datapath pieces
  always_comb begin
    delta    = MAG_BITS'(x_r) - MAG_BITS'(mean_r);
    dabs     = delta[MAG_BITS-1] ? MAG_BITS'(-delta) : MAG_BITS'(delta);
    quot     = div_rsp.quotient[MAG_BITS-1:0];
    step_val = dneg_r ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
    mean_sum = (MAG_BITS + 1)'(mean_r) + step_val;

    unique case (mstep_r)
      MS_LH: begin
        op_a = dabs_r[HALF_BITS-1:0];
        op_b = HALF_BITS'(babs_r[MAG_BITS-1:HALF_BITS]);
      end
      MS_HL: begin
        op_a = HALF_BITS'(dabs_r[MAG_BITS-1:HALF_BITS]);
        op_b = babs_r[HALF_BITS-1:0];
      end
      MS_HH: begin
        op_a = HALF_BITS'(dabs_r[MAG_BITS-1:HALF_BITS]);
        op_b = HALF_BITS'(babs_r[MAG_BITS-1:HALF_BITS]);
      end
      default: begin
        op_a = dabs_r[HALF_BITS-1:0];
        op_b = babs_r[HALF_BITS-1:0];
      end
    endcase
    pp = op_a * op_b;

    unique case (mstep_r)
      MS_LH, MS_HL: add_term = ACC_BITS'(pp) << HALF_BITS;
      MS_HH:        add_term = ACC_BITS'(pp) << (2 * HALF_BITS);
      default:      add_term = ACC_BITS'(pp);
    endcase

    // spread sum saturates at all ones
    m2_sum = {1'b0, m2_r} + {1'b0, VAR_BITS'(acc_r)};
    m2_sat = m2_sum[VAR_BITS] ? '1 : m2_sum[VAR_BITS-1:0];

    wide_count = WIDE_BITS'(count_r);
    total      = (wide_count > WIDE_BITS'(TOTAL_MAX)) ? '1 : wide_count[TOTAL_BITS-1:0];
    base_count = item.start ? '0 : count_r;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    mean_nxt   = mean_r;
    m2_nxt     = m2_r;
    x_nxt      = x_r;
    dabs_nxt   = dabs_r;
    dneg_nxt   = dneg_r;
    babs_nxt   = babs_r;
    acc_nxt    = acc_r;
    mstep_nxt  = mstep_r;
    var_nxt    = var_r;
    vv_nxt     = vv_r;
    ov_nxt     = ov_r;
    otot_nxt   = otot_r;
    omean_nxt  = omean_r;
    ovar_nxt   = ovar_r;
    ovv_nxt    = ovv_r;
    item_ready = 1'b0;
    div_req    = '0;

    if (out_chan.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_ready = 1'b1;
          // the count sticks at its maximum, the update still runs
          count_nxt  = (base_count == '1) ? base_count : base_count + COUNT_BITS'(1);
          mean_nxt   = item.start ? '0 : mean_r;
          m2_nxt     = item.start ? '0 : m2_r;
          x_nxt      = item.sample;
          state_nxt  = ST_PREP;
        end
      end
      ST_PREP: begin
        dabs_nxt         = dabs;
        dneg_nxt         = delta[MAG_BITS-1];
        div_req.start    = 1'b1;
        div_req.dividend = DIV_BITS'(dabs) << (DIV_BITS - MAG_BITS);
        div_req.divisor  = count_r;
        div_req.steps    = DIV_STEP_BITS'(MAG_BITS);
        state_nxt        = ST_DMEAN;
      end
      ST_DMEAN: begin
        if (div_rsp.done) begin
          mean_nxt  = mean_sum[SAMPLE_BITS-1:0];
          acc_nxt   = '0;
          mstep_nxt = MS_LOAD;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // first step takes the distance of the sample from the new mean
        if (mstep_r == MS_LOAD) begin
          babs_nxt = dabs;
        end else begin
          acc_nxt = acc_r + add_term;
        end
        mstep_nxt = mstep_r + 3'd1;
        if (mstep_r == MS_HH) begin
          state_nxt = ST_VPREP;
        end
      end
      ST_VPREP: begin
        m2_nxt = m2_sat;
        if (count_r >= COUNT_BITS'(2)) begin
          div_req.start    = 1'b1;
          div_req.dividend = m2_sat;
          div_req.divisor  = count_r - COUNT_BITS'(1);
          div_req.steps    = DIV_STEP_BITS'(DIV_BITS);
          state_nxt        = ST_DVAR;
        end else begin
          var_nxt   = '0;
          vv_nxt    = 1'b0;
          state_nxt = ST_OUT;
        end
      end
      ST_DVAR: begin
        if (div_rsp.done) begin
          var_nxt   = div_rsp.quotient;
          vv_nxt    = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_chan.ready) begin
          ov_nxt    = 1'b1;
          otot_nxt  = total;
          omean_nxt = MEAN_BITS'(mean_r);
          ovar_nxt  = var_r;
          ovv_nxt   = vv_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      mean_r  <= '0;
      m2_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      mean_r  <= mean_nxt;
      m2_r    <= m2_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    dabs_r  <= dabs_nxt;
    dneg_r  <= dneg_nxt;
    babs_r  <= babs_nxt;
    acc_r   <= acc_nxt;
    mstep_r <= mstep_nxt;
    var_r   <= var_nxt;
    vv_r    <= vv_nxt;
    otot_r  <= otot_nxt;
    omean_r <= omean_nxt;
    ovar_r  <= ovar_nxt;
    ovv_r   <= ovv_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/rmv_checker.sv
// port-level checks of the running mean and variance block, bound to the top level
`default_nettype none
`include "running_mean_variance_assert.svh"

module rmv_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sample_total,
  input logic [31:0] out_mean_value,
  input logic [63:0] out_variance_value,
  input logic        out_variance_valid
);

  logic [128:0] out_bus;
  logic         two_held;

  assign out_bus  = {out_sample_total, out_mean_value, out_variance_value, out_variance_valid};
  assign two_held = (out_sample_total >= 32'd2);

  // a stalled result holds
  `RMV_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid && $stable(out_bus))

  // nothing is offered straight after reset
  `RMV_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, !rst_n, !out_valid)

  // variance is valid exactly when two or more samples are held
  `RMV_ASSERT_IMP(a_var_flag, clk, !rst_n, out_valid, out_variance_valid == two_held)

  // an invalid variance reads zero
  `RMV_ASSERT_IMP(a_var_zero, clk, !rst_n, out_valid && !out_variance_valid, out_variance_value == '0)

endmodule

bind running_mean_variance rmv_port_checker u_rmv_port_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_sample_total   (out_chan.sample_total),
  .out_mean_value     (out_chan.mean_value),
  .out_variance_value (out_chan.variance_value),
  .out_variance_valid (out_chan.variance_valid)
);

`default_nettype wire
